// ===== src/idst_pkg.sv =====
// ----------------------------------------------------------------------------
// idst_pkg
// Shared constants, field widths, action codes and the slot type for the
// identifier slot table.
// ----------------------------------------------------------------------------
package idst_pkg;

  localparam int SLOTS    = 16;
  localparam int LIST_MAX = 8;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OCC_W  = $clog2(SLOTS + 1);
  localparam int LIST_W = $clog2(LIST_MAX + 1);

  // item field widths
  localparam int ACTION_W   = 3;
  localparam int ID_W       = 32;
  localparam int SEL_W      = 4;
  localparam int SKIP_W     = 5;
  localparam int SLOT_NUM_W = 4;
  localparam int OCC_OUT_W  = 5;

  localparam int CMP_W  = $clog2(SLOTS + LIST_MAX + (1 << SKIP_W)) + 1;
  localparam int CMPS_W = (SLOT_W > SEL_W) ? SLOT_W : SEL_W;

  localparam int IN_FIELDS_W  = ID_W + SEL_W + SKIP_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_NUM_W + ID_W + 1 + OCC_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 3'd0,
    ACT_FIND    = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_READ    = 3'd3,
    ACT_LIST    = 3'd4
  } action_e;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } slot_t;

endpackage

// ===== src/idst_cell.sv =====
// ----------------------------------------------------------------------------
// idst_cell
// One slot of the rotating table: a valid bit and an identifier that move to
// the neighboring cell whenever the ring steps.
// ----------------------------------------------------------------------------
module idst_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  idst_pkg::slot_t slot_i,
  output idst_pkg::slot_t slot_o
);
  import idst_pkg::*;

  logic            valid_q;
  logic [ID_W-1:0] id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q <= slot_i.id;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.id    = id_q;

endmodule

// ===== src/idst_ctrl.sv =====
// ----------------------------------------------------------------------------
// idst_ctrl
// Walk controller: takes one item, steps the ring once around while looking
// at the head cell, updates the head on allocate and release, and drives the
// result register.
// ----------------------------------------------------------------------------
module idst_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [idst_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [idst_pkg::ACTION_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [idst_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast,
  input  idst_pkg::slot_t                     head_i,
  output idst_pkg::slot_t                     head_o,
  output logic                                shift_o
);
  import idst_pkg::*;

  typedef enum logic {ST_IDLE, ST_WALK} state_e;

  state_e                state_q;
  logic [ACTION_W-1:0]   act_q;
  logic [ID_W-1:0]       key_q;
  logic [SEL_W-1:0]      sel_q;
  logic [SKIP_W-1:0]     skip_left_q;
  logic [LIST_W-1:0]     pick_cnt_q, n_q;
  logic                  more_q, need_final_q;
  logic [SLOT_W-1:0]     pos_q;
  logic [OCC_W-1:0]      occ_q, occ_d;

  logic                  m_valid_q, m_last_q, m_user_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  logic [ID_W-1:0]       in_key;
  logic [SEL_W-1:0]      in_sel;
  logic [SKIP_W-1:0]     in_skip;
  logic [CMP_W-1:0]      avail;
  logic [LIST_W-1:0]     in_n;
  logic                  in_more;

  logic                  walking, hit, last_step, emit, stall, step;
  logic                  r_status, r_last, r_more;
  logic [SLOT_NUM_W-1:0] r_slot;
  logic [ID_W-1:0]       r_id;
  logic [OUT_TDATA_W-1:0] r_data;

  // input unpacking and list bounds from the current occupancy
  assign in_key  = s_tdata[ID_W-1:0];
  assign in_sel  = s_tdata[ID_W +: SEL_W];
  assign in_skip = s_tdata[ID_W+SEL_W +: SKIP_W];

  always_comb begin
    if (CMP_W'(occ_q) > CMP_W'(in_skip)) begin
      avail = CMP_W'(occ_q) - CMP_W'(in_skip);
    end else begin
      avail = '0;
    end
    in_more = avail > CMP_W'(LIST_MAX);
    in_n    = in_more ? LIST_W'(LIST_MAX) : LIST_W'(avail);
  end

  assign walking   = (state_q == ST_WALK);
  assign last_step = (pos_q == SLOT_W'(SLOTS - 1));

  always_comb begin
    case (act_q)
      ACT_ALLOC:   hit = need_final_q && !head_i.valid;
      ACT_FIND, ACT_RELEASE:
        hit = need_final_q && head_i.valid && (head_i.id == key_q);
      ACT_READ:    hit = need_final_q && (CMPS_W'(pos_q) == CMPS_W'(sel_q));
      ACT_LIST:    hit = head_i.valid && (skip_left_q == '0) && (pick_cnt_q < n_q);
      default:     hit = 1'b0;
    endcase
  end

  assign emit    = walking && (hit || (last_step && need_final_q));
  assign stall   = emit && m_valid_q && !m_tready;
  assign step    = walking && !stall;
  assign shift_o = step;

  // head write-back and occupancy after the operation
  always_comb begin
    head_o = head_i;
    occ_d  = occ_q;
    if (step && hit) begin
      if (act_q == ACT_ALLOC) begin
        head_o.valid = 1'b1;
        head_o.id    = key_q;
        occ_d        = occ_q + OCC_W'(1);
      end else if (act_q == ACT_RELEASE) begin
        head_o.valid = 1'b0;
        occ_d        = occ_q - OCC_W'(1);
      end
    end
  end

  // result fields
  always_comb begin
    r_status = 1'b1;
    r_slot   = '0;
    r_id     = '0;
    r_last   = 1'b1;
    r_more   = 1'b0;
    if (hit) begin
      case (act_q)
        ACT_ALLOC: begin
          r_status = 1'b0;
          r_slot   = SLOT_NUM_W'(pos_q);
          r_id     = key_q;
        end
        ACT_FIND, ACT_RELEASE: begin
          r_status = 1'b0;
          r_slot   = SLOT_NUM_W'(pos_q);
          r_id     = head_i.id;
        end
        ACT_READ: begin
          r_status = !head_i.valid;
          r_slot   = sel_q;
          r_id     = head_i.valid ? head_i.id : '0;
        end
        ACT_LIST: begin
          r_status = 1'b0;
          r_slot   = SLOT_NUM_W'(pos_q);
          r_id     = head_i.id;
          r_last   = ((pick_cnt_q + LIST_W'(1)) == n_q);
          r_more   = more_q;
        end
        default: begin
          r_status = 1'b1;
        end
      endcase
    end else if (act_q == ACT_READ) begin
      r_slot = sel_q;
    end
    r_data = '0;
    r_data[OUT_FIELDS_W-1:0] = {OCC_OUT_W'(occ_d), r_more, r_id, r_slot};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      act_q        <= '0;
      sel_q        <= '0;
      skip_left_q  <= '0;
      pick_cnt_q   <= '0;
      n_q          <= '0;
      more_q       <= 1'b0;
      need_final_q <= 1'b0;
      pos_q        <= '0;
      occ_q        <= '0;
      m_valid_q    <= 1'b0;
      m_last_q     <= 1'b0;
      m_user_q     <= 1'b0;
    end else begin
      if (state_q == ST_IDLE) begin
        if (s_tvalid) begin
          state_q      <= ST_WALK;
          act_q        <= s_tuser;
          sel_q        <= in_sel;
          skip_left_q  <= in_skip;
          pick_cnt_q   <= '0;
          pos_q        <= '0;
          if (s_tuser == ACT_LIST) begin
            n_q          <= in_n;
            more_q       <= in_more;
            need_final_q <= (in_n == '0);
          end else begin
            n_q          <= '0;
            more_q       <= 1'b0;
            need_final_q <= 1'b1;
          end
        end
      end else if (step) begin
        occ_q <= occ_d;
        if (emit) begin
          need_final_q <= 1'b0;
        end
        if (act_q == ACT_LIST && head_i.valid && skip_left_q != '0) begin
          skip_left_q <= skip_left_q - SKIP_W'(1);
        end
        if (act_q == ACT_LIST && hit) begin
          pick_cnt_q <= pick_cnt_q + LIST_W'(1);
        end
        if (last_step) begin
          pos_q   <= '0;
          state_q <= ST_IDLE;
        end else begin
          pos_q <= pos_q + SLOT_W'(1);
        end
      end

      if (emit && step) begin
        m_valid_q <= 1'b1;
        m_last_q  <= r_last;
        m_user_q  <= r_status;
      end else if (m_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_tvalid) begin
      key_q <= in_key;
    end
    if (emit && step) begin
      m_data_q <= r_data;
    end
  end

  assign s_tready = (state_q == ST_IDLE);
  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;
  assign m_tuser  = m_user_q;
  assign m_tlast  = m_last_q;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(SLOTS))
    else $error("occupancy above table size");

  a_pick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_cnt_q <= n_q)
    else $error("list gave more entries than planned");

  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walking && step && last_step) |=> (!need_final_q && pick_cnt_q == n_q))
    else $error("walk ended with a result still owed");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && hit && act_q == ACT_ALLOC) |=> (occ_q == $past(occ_q) + OCC_W'(1)))
    else $error("allocate did not raise occupancy");

endmodule

// ===== src/id_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// id_slot_table_top
// Identifier slot table built as a ring of slot cells that rotates past one
// compare point.
// ----------------------------------------------------------------------------
// The item is taken while the controller is idle; then the slot cells, which form
// a ring, step one slot per cycle, held while the result side stalls, past a
// single compare and write-back point, and an item is done when the ring has gone
// once around and is back in slot order. One item is in work at a time; the next
// is taken in the cycle after the walk ends, even while the last result still
// sits in the output register. A list item gives up to LIST_MAX results, one per
// cycle at most. No clearing pass is needed after reset.
module id_slot_table_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // key_id [31:0], slot_select [35:32], skip_count [40:36], zero pad
  input  logic [idst_pkg::IN_TDATA_W-1:0]   s_tdata,
  // action [2:0]
  input  logic [idst_pkg::ACTION_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot_number [3:0], id_out [35:4], more_flag [36], occupancy [41:37], zero pad
  output logic [idst_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // status [0]
  output logic                              m_tuser,
  output logic                              m_tlast
);
  import idst_pkg::*;

  slot_t ring [SLOTS];
  slot_t head_wr;
  logic  shift;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    idst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i ((g == SLOTS - 1) ? head_wr : ring[(g + 1) % SLOTS]),
      .slot_o (ring[g])
    );
  end

  idst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .head_i  (ring[0]),
    .head_o  (head_wr),
    .shift_o (shift)
  );

endmodule

// ===== dv/id_slot_table_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_slot_table_top_tb
// Self-checking bench for the identifier slot table. A short directed table
// walks empty, full, duplicate and list-window cases, then a random phase
// alternates between filling and draining the table with keys mostly taken
// from live slots. A shadow copy of the table predicts every result item,
// and results are compared in order while both stream sides idle at random.
// ----------------------------------------------------------------------------
module id_slot_table_top_tb;
  import idst_pkg::*;

  localparam int          RAND_ITEMS = 185;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          DRAIN_WAIT = 40;
  localparam logic        ST_OK      = 1'b0;
  localparam logic        ST_MISS    = 1'b1;
  localparam int          NUM_ROWS   = 23;

  typedef struct {
    logic                  status;
    logic [SLOT_NUM_W-1:0] slot;
    logic [ID_W-1:0]       id;
    logic                  last;
    logic                  more;
    logic [OCC_OUT_W-1:0]  occ;
  } slot_result_t;

  typedef struct {
    action_e               act;
    logic [ID_W-1:0]       key_id;
    logic [SEL_W-1:0]      sel;
    logic [SKIP_W-1:0]     skip;
    int                    reps;
    bit                    typed;
    slot_result_t          want;
  } stim_row_t;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [ACTION_W-1:0]    s_tuser  = ACT_ALLOC;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  id_slot_table_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow table
  bit              shadow_valid [SLOTS];
  logic [ID_W-1:0] shadow_id    [SLOTS];

  slot_result_t item_results[$];
  slot_result_t pending_results[$];
  stim_row_t    dir_rows [NUM_ROWS];

  int err_count    = 0;
  int idle_cycles  = 0;
  int n_checked    = 0;
  int n_full       = 0;
  int n_empty_list = 0;
  int n_more       = 0;
  int n_by_act [5];
  int burst_left   = 0;

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (shadow_valid[i]) n++;
    return n;
  endfunction

  function automatic void add_result(logic st, int slot, logic [ID_W-1:0] id, logic last,
                                     logic more);
    slot_result_t r;
    r.status = st;
    r.slot   = slot[SLOT_NUM_W-1:0];
    r.id     = id;
    r.last   = last;
    r.more   = more;
    r.occ    = OCC_OUT_W'(live_count());
    item_results.push_back(r);
  endfunction

  function automatic void apply_action(action_e act, logic [ID_W-1:0] key_id,
                                       logic [SEL_W-1:0] sel, logic [SKIP_W-1:0] skip);
    int hit;
    int n;
    int skipped;
    logic more;
    int picks [LIST_MAX];
    hit     = -1;
    n       = 0;
    skipped = 0;
    more    = 1'b0;
    item_results.delete();
    case (act)
      ACT_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) if (!shadow_valid[i] && hit < 0) hit = i;
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b1;
          shadow_id[hit]    = key_id;
          add_result(ST_OK, hit, key_id, 1'b1, 1'b0);
        end else begin
          add_result(ST_MISS, 0, '0, 1'b1, 1'b0);
        end
      end
      ACT_FIND, ACT_RELEASE: begin
        for (int i = 0; i < SLOTS; i++)
          if (shadow_valid[i] && shadow_id[i] == key_id && hit < 0) hit = i;
        if (hit < 0) begin
          add_result(ST_MISS, 0, '0, 1'b1, 1'b0);
        end else begin
          if (act == ACT_RELEASE) shadow_valid[hit] = 1'b0;
          add_result(ST_OK, hit, shadow_id[hit], 1'b1, 1'b0);
        end
      end
      ACT_READ: begin
        if (shadow_valid[sel]) add_result(ST_OK, int'(sel), shadow_id[sel], 1'b1, 1'b0);
        else add_result(ST_MISS, int'(sel), '0, 1'b1, 1'b0);
      end
      ACT_LIST: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_valid[i] && !more) begin
            if (skipped < skip) skipped++;
            else if (n == LIST_MAX) more = 1'b1;
            else begin
              picks[n] = i;
              n++;
            end
          end
        end
        if (n == 0) add_result(ST_MISS, 0, '0, 1'b1, 1'b0);
        for (int k = 0; k < n; k++)
          add_result(ST_OK, picks[k], shadow_id[picks[k]], k + 1 == n, more);
      end
      default: add_result(ST_MISS, 0, '0, 1'b1, 1'b0);
    endcase
  endfunction

  function automatic stim_row_t mk_row(action_e act, logic [ID_W-1:0] key_id, int sel, int skip,
                                       int reps, bit typed, logic st, int slot,
                                       logic [ID_W-1:0] id, int occ);
    stim_row_t row;
    row.act         = act;
    row.key_id      = key_id;
    row.sel         = sel[SEL_W-1:0];
    row.skip        = skip[SKIP_W-1:0];
    row.reps        = reps;
    row.typed       = typed;
    row.want.status = st;
    row.want.slot   = slot[SLOT_NUM_W-1:0];
    row.want.id     = id;
    row.want.last   = 1'b1;
    row.want.more   = 1'b0;
    row.want.occ    = occ[OCC_OUT_W-1:0];
    return row;
  endfunction

  // mostly keys of live slots so find and release hit, some fixed keys for duplicates
  function automatic logic [ID_W-1:0] pick_key();
    int start;
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && live_count() > 0) begin
      start = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++)
        if (shadow_valid[(start + i) % SLOTS]) return shadow_id[(start + i) % SLOTS];
    end
    if (r < 8) begin
      case ($urandom_range(0, 2))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        default: return 32'hA5A5_5A5A;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_item(action_e act, logic [ID_W-1:0] key_id, logic [SEL_W-1:0] sel,
                           logic [SKIP_W-1:0] skip);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, skip, sel, key_id};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    apply_action(act, key_id, sel, skip);
    n_by_act[act]++;
    if (act == ACT_ALLOC && item_results[0].status == ST_MISS) n_full++;
    if (act == ACT_LIST && item_results[0].status == ST_MISS) n_empty_list++;
    if (act == ACT_LIST && item_results[0].more) n_more++;
  endtask

  // receiver stalls: always ready, random, or a fixed pattern
  logic [12:0] stall_pat = 13'b1011001110100;
  int          rcv_cyc   = 0;

  always @(posedge clk_i) begin
    rcv_cyc <= rcv_cyc + 1;
    case ((rcv_cyc / 97) % 3)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      default: m_tready <= stall_pat[rcv_cyc % 13];
    endcase
  end

  task automatic check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    slot_result_t want;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: tdata %0h", m_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("status", ID_W'(want.status), ID_W'(m_tuser));
        check_field("slot_number", ID_W'(want.slot), ID_W'(m_tdata[3:0]));
        check_field("id_out", want.id, m_tdata[35:4]);
        check_field("last", ID_W'(want.last), ID_W'(m_tlast));
        check_field("more_flag", ID_W'(want.more), ID_W'(m_tdata[36]));
        check_field("occupancy", ID_W'(want.occ), ID_W'(m_tdata[41:37]));
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d idle cycles", idle_cycles);
    $display("id_slot_table_top_tb: FAIL");
    $finish;
  end

  initial begin
    int r;
    action_e act;
    for (int i = 0; i < 5; i++) n_by_act[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_id[i]    = '0;
    end
    dir_rows[0]  = mk_row(ACT_LIST,    32'h0,         0,  0,  1, 1, ST_MISS, 0,  32'h0, 0);
    dir_rows[1]  = mk_row(ACT_READ,    32'h0,         15, 0,  1, 1, ST_MISS, 15, 32'h0, 0);
    dir_rows[2]  = mk_row(ACT_FIND,    32'h0,         0,  0,  1, 1, ST_MISS, 0,  32'h0, 0);
    dir_rows[3]  = mk_row(ACT_RELEASE, 32'hFFFF_FFFF, 0,  0,  1, 1, ST_MISS, 0,  32'h0, 0);
    dir_rows[4]  = mk_row(ACT_ALLOC,   32'h0,         0,  0,  1, 1, ST_OK,   0,  32'h0, 1);
    dir_rows[5]  = mk_row(ACT_ALLOC,   32'hFFFF_FFFF, 0,  0,  1, 1, ST_OK,   1,
                          32'hFFFF_FFFF, 2);
    // duplicate key lands in the next free slot
    dir_rows[6]  = mk_row(ACT_ALLOC,   32'h0,         0,  0,  1, 1, ST_OK,   2,  32'h0, 3);
    dir_rows[7]  = mk_row(ACT_FIND,    32'h0,         0,  0,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[8]  = mk_row(ACT_READ,    32'h0,         1,  0,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[9]  = mk_row(ACT_ALLOC,   32'h1000_0000, 0,  0,  13, 0, ST_OK,  0,  32'h0, 0);
    dir_rows[10] = mk_row(ACT_ALLOC,   32'hDEAD_BEEF, 0,  0,  1, 1, ST_MISS, 0,  32'h0, 16);
    dir_rows[11] = mk_row(ACT_LIST,    32'h0,         0,  0,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[12] = mk_row(ACT_LIST,    32'h0,         0,  8,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[13] = mk_row(ACT_LIST,    32'h0,         0,  16, 1, 1, ST_MISS, 0,  32'h0, 16);
    dir_rows[14] = mk_row(ACT_LIST,    32'h0,         0,  15, 1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[15] = mk_row(ACT_RELEASE, 32'h0,         0,  0,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[16] = mk_row(ACT_FIND,    32'h0,         0,  0,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[17] = mk_row(ACT_READ,    32'h0,         0,  0,  1, 1, ST_MISS, 0,  32'h0, 15);
    dir_rows[18] = mk_row(ACT_RELEASE, 32'hFFFF_FFFF, 0,  0,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[19] = mk_row(ACT_READ,    32'h0,         1,  0,  1, 1, ST_MISS, 1,  32'h0, 14);
    dir_rows[20] = mk_row(ACT_ALLOC,   32'h5555_AAAA, 0,  0,  1, 1, ST_OK,   0,
                          32'h5555_AAAA, 15);
    dir_rows[21] = mk_row(ACT_READ,    32'h0,         10, 0,  1, 0, ST_OK,   0,  32'h0, 0);
    dir_rows[22] = mk_row(ACT_LIST,    32'h0,         0,  3,  1, 0, ST_OK,   0,  32'h0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int d = 0; d < NUM_ROWS; d++) begin
      for (int k = 0; k < dir_rows[d].reps; k++) begin
        send_item(dir_rows[d].act, dir_rows[d].key_id + k, dir_rows[d].sel, dir_rows[d].skip);
        if (dir_rows[d].typed) pending_results.push_back(dir_rows[d].want);
        else foreach (item_results[j]) pending_results.push_back(item_results[j]);
      end
    end

    // alternate fill-heavy and drain-heavy stretches so occupancy swings end to end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if ((i / 55) % 2 == 0) begin
        if (r < 45) act = ACT_ALLOC;
        else if (r < 60) act = ACT_FIND;
        else if (r < 70) act = ACT_RELEASE;
        else if (r < 85) act = ACT_READ;
        else act = ACT_LIST;
      end else begin
        if (r < 10) act = ACT_ALLOC;
        else if (r < 30) act = ACT_FIND;
        else if (r < 70) act = ACT_RELEASE;
        else if (r < 85) act = ACT_READ;
        else act = ACT_LIST;
      end
      send_item(act, pick_key(), SEL_W'($urandom_range(0, SLOTS - 1)),
                SKIP_W'($urandom_range(0, 16)));
      foreach (item_results[j]) pending_results.push_back(item_results[j]);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d items: alloc %0d, find %0d, release %0d, read %0d, list %0d; %0d results",
             n_by_act[0] + n_by_act[1] + n_by_act[2] + n_by_act[3] + n_by_act[4],
             n_by_act[0], n_by_act[1], n_by_act[2], n_by_act[3], n_by_act[4], n_checked);
    $display("allocs refused on a full table %0d, empty lists %0d, lists with more set %0d",
             n_full, n_empty_list, n_more);
    if (err_count == 0) begin
      $display("id_slot_table_top_tb: PASS");
    end else begin
      $display("id_slot_table_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/idst_pkg.sv
src/idst_cell.sv
src/idst_ctrl.sv
src/id_slot_table_top.sv
dv/id_slot_table_top_tb.sv
